/* rtl/scs1_pkg.sv */
// ----------------------------------------------------------------------------
// scs1_pkg
// Shared types, constants and the letter key table for the scan-code-set-1
// to ASCII decoder.
// ----------------------------------------------------------------------------
package scs1_pkg;

	localparam int MOD_COUNT_BITS_DEF = 4;

	localparam logic [7:0] ESC_PREFIX   = 8'hE0;
	localparam logic [7:0] PAUSE_PREFIX = 8'hE1;
	localparam logic [2:0] PAUSE_SKIP   = 3'd5;

	localparam logic [6:0] KEY_SHIFT_LEFT  = 7'h2A;
	localparam logic [6:0] KEY_SHIFT_RIGHT = 7'h36;
	localparam logic [6:0] KEY_ALT         = 7'h38;
	localparam logic [6:0] KEY_CTRL        = 7'h1D;

	localparam logic [6:0] CASE_OFFSET = 7'h20;
	localparam logic [6:0] NO_LETTER   = 7'h00;
	localparam logic [6:0] CHAR_UPPER_A = 7'h41;
	localparam logic [6:0] CHAR_UPPER_Z = 7'h5A;
	localparam logic [6:0] CHAR_LOWER_A = 7'h61;
	localparam logic [6:0] CHAR_LOWER_Z = 7'h7A;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_SHIFT,
		OP_ALT,
		OP_CTRL,
		OP_LETTER
	} scs1_op_t;

	typedef struct packed {
		scs1_op_t   op;
		logic       up;
		logic [6:0] letter;
	} scs1_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} scs1_q_stat_t;

	// Lowercase ASCII letter for a make code, or NO_LETTER for other keys.
	function automatic logic [6:0] letter_of(input logic [6:0] code);
		logic [6:0] ch;
		ch = NO_LETTER;
		unique case (code)
			7'h10: ch = 7'h71;
			7'h11: ch = 7'h77;
			7'h12: ch = 7'h65;
			7'h13: ch = 7'h72;
			7'h14: ch = 7'h74;
			7'h15: ch = 7'h79;
			7'h16: ch = 7'h75;
			7'h17: ch = 7'h69;
			7'h18: ch = 7'h6F;
			7'h19: ch = 7'h70;
			7'h1E: ch = 7'h61;
			7'h1F: ch = 7'h73;
			7'h20: ch = 7'h64;
			7'h21: ch = 7'h66;
			7'h22: ch = 7'h67;
			7'h23: ch = 7'h68;
			7'h24: ch = 7'h6A;
			7'h25: ch = 7'h6B;
			7'h26: ch = 7'h6C;
			7'h2C: ch = 7'h7A;
			7'h2D: ch = 7'h78;
			7'h2E: ch = 7'h63;
			7'h2F: ch = 7'h76;
			7'h30: ch = 7'h62;
			7'h31: ch = 7'h6E;
			7'h32: ch = 7'h6D;
			default: ch = NO_LETTER;
		endcase
		return ch;
	endfunction

endpackage

/* rtl/scs1_if.sv */
// ----------------------------------------------------------------------------
// scs1_if
// Valid/ready channel interfaces for scan bytes and ASCII characters.
// ----------------------------------------------------------------------------
interface scs1_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] scan_byte;

	modport source (output valid, output scan_byte, input ready);
	modport sink (input valid, input scan_byte, output ready);
endinterface

interface scs1_out_if;
	logic       valid;
	logic       ready;
	logic [6:0] ascii_char;

	modport source (output valid, output ascii_char, input ready);
	modport sink (input valid, input ascii_char, output ready);
endinterface

/* rtl/scs1_front.sv */
// ----------------------------------------------------------------------------
// scs1_front
// Accepts scan bytes, tracks prefix state and classifies each code into a
// command for the back end.
// ----------------------------------------------------------------------------
module scs1_front
	import scs1_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    scan_byte,
	input  scs1_q_stat_t  q_stat,
	output logic          push,
	output scs1_cmd_t     push_cmd
);

	logic       esc_q;
	logic [2:0] skip_q;
	logic       esc_d;
	logic [2:0] skip_d;
	logic       accept;
	logic       make;
	logic [6:0] code;
	logic [6:0] letter;

	assign in_ready = !q_stat.full;
	assign accept   = in_valid && in_ready;
	assign make     = !scan_byte[7];
	assign code     = scan_byte[6:0];
	assign letter   = letter_of(code);

	always_comb begin
		esc_d           = esc_q;
		skip_d          = skip_q;
		push_cmd.op     = OP_NONE;
		push_cmd.up     = make;
		push_cmd.letter = letter;
		if (skip_q != 3'd0) begin
			skip_d = skip_q - 3'd1;
		end else if (scan_byte == ESC_PREFIX) begin
			esc_d = 1'b1;
		end else if (scan_byte == PAUSE_PREFIX) begin
			skip_d = PAUSE_SKIP;
		end else begin
			esc_d = 1'b0;
			if (!esc_q && (code == KEY_SHIFT_LEFT || code == KEY_SHIFT_RIGHT)) begin
				push_cmd.op = OP_SHIFT;
			end else if (code == KEY_ALT) begin
				push_cmd.op = OP_ALT;
			end else if (code == KEY_CTRL) begin
				push_cmd.op = OP_CTRL;
			end else if (make && !esc_q && letter != NO_LETTER) begin
				push_cmd.op = OP_LETTER;
			end
		end
	end

	assign push = accept && (push_cmd.op != OP_NONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q  <= 1'b0;
			skip_q <= 3'd0;
		end else if (accept) begin
			esc_q  <= esc_d;
			skip_q <= skip_d;
		end
	end

endmodule

/* rtl/scs1_fifo.sv */
// ----------------------------------------------------------------------------
// scs1_fifo
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module scs1_fifo
	import scs1_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  scs1_cmd_t    push_cmd,
	input  logic         pop,
	output scs1_cmd_t    pop_cmd,
	output scs1_q_stat_t q_stat
);

	scs1_cmd_t  entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign q_stat.full  = (count_q == 2'd2);
	assign q_stat.empty = (count_q == 2'd0);
	assign pop_cmd      = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

/* rtl/scs1_back.sv */
// ----------------------------------------------------------------------------
// scs1_back
// Executes queued commands: modifier press counters and letter output with
// an output register.
// ----------------------------------------------------------------------------
module scs1_back
	import scs1_pkg::*;
#(
	parameter int MOD_COUNT_BITS = MOD_COUNT_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  scs1_cmd_t    pop_cmd,
	input  scs1_q_stat_t q_stat,
	output logic         pop,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [6:0]   ascii_char
);

	localparam logic [MOD_COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [MOD_COUNT_BITS-1:0] COUNT_ZERO = '0;
	localparam logic [MOD_COUNT_BITS-1:0] COUNT_ONE = MOD_COUNT_BITS'(1);

	logic [MOD_COUNT_BITS-1:0] shift_q;
	logic [MOD_COUNT_BITS-1:0] alt_q;
	logic [MOD_COUNT_BITS-1:0] ctrl_q;
	logic                      out_valid_q;
	logic [6:0]                char_q;
	logic                      emit;

	function automatic logic [MOD_COUNT_BITS-1:0] bump(
		input logic [MOD_COUNT_BITS-1:0] cnt,
		input logic                      up
	);
		logic [MOD_COUNT_BITS-1:0] res;
		res = cnt;
		if (up && cnt != COUNT_MAX) begin
			res = cnt + COUNT_ONE;
		end else if (!up && cnt != COUNT_ZERO) begin
			res = cnt - COUNT_ONE;
		end
		return res;
	endfunction

	assign pop        = !q_stat.empty && (!out_valid_q || out_ready);
	assign emit       = pop && (pop_cmd.op == OP_LETTER) &&
	                    (alt_q == COUNT_ZERO) && (ctrl_q == COUNT_ZERO);
	assign out_valid  = out_valid_q;
	assign ascii_char = char_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q     <= COUNT_ZERO;
			alt_q       <= COUNT_ZERO;
			ctrl_q      <= COUNT_ZERO;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				unique case (pop_cmd.op)
					OP_SHIFT: shift_q <= bump(shift_q, pop_cmd.up);
					OP_ALT:   alt_q   <= bump(alt_q, pop_cmd.up);
					OP_CTRL:  ctrl_q  <= bump(ctrl_q, pop_cmd.up);
					default: begin
					end
				endcase
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			char_q <= (shift_q != COUNT_ZERO) ? (pop_cmd.letter - CASE_OFFSET)
			                                  : pop_cmd.letter;
		end
	end

endmodule

/* rtl/scancode_set1_to_ascii.sv */
// A letter byte accepted into an empty queue is written into the command queue, then popped
// into the output register, from which its transaction is offered.
// Throughput: one scan byte per cycle while the command queue is not full.
// The two-entry command queue holds up to two commands while the output stalls.
// Reset clears the prefix state, the press counters, the queue and the output valid flag.
// ----------------------------------------------------------------------------
// scancode_set1_to_ascii
// Scan-code-set-1 keyboard decoder producing ASCII letters.
// ----------------------------------------------------------------------------
module scancode_set1_to_ascii
	import scs1_pkg::*;
#(
	parameter int MOD_COUNT_BITS = MOD_COUNT_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	scs1_in_if.sink           in_ch,
	scs1_out_if.source        out_ch
);

	scs1_q_stat_t q_stat;
	scs1_cmd_t    push_cmd;
	scs1_cmd_t    pop_cmd;
	logic         push;
	logic         pop;

	scs1_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.scan_byte (in_ch.scan_byte),
		.q_stat    (q_stat),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	scs1_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.q_stat   (q_stat)
	);

	scs1_back #(
		.MOD_COUNT_BITS (MOD_COUNT_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_cmd    (pop_cmd),
		.q_stat     (q_stat),
		.pop        (pop),
		.out_valid  (out_ch.valid),
		.out_ready  (out_ch.ready),
		.ascii_char (out_ch.ascii_char)
	);

endmodule

/* rtl/scs1_checker.sv */
// ----------------------------------------------------------------------------
// scs1_checker
// Port-level assertions for the scan code decoder, bound to the top level.
// ----------------------------------------------------------------------------
module scs1_checker
	import scs1_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [6:0] ascii_char
);

	// Every offered character is an ASCII letter.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((ascii_char >= CHAR_UPPER_A && ascii_char <= CHAR_UPPER_Z) ||
		               (ascii_char >= CHAR_LOWER_A && ascii_char <= CHAR_LOWER_Z)))
		else $error("output transaction is not an ASCII letter");

	// The input only backs up when a result is waiting to be taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no pending output transaction");

	// A stalled output transaction holds its character.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(ascii_char))
		else $error("stalled output transaction changed");

endmodule

bind scancode_set1_to_ascii scs1_checker u_scs1_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.ascii_char (out_ch.ascii_char)
);
